// File: sv/bpa_pkg.sv
// Shared types and constants for the button press and autorepeat block.
// Used by every module of the block; has no dependencies of its own.

package bpa_pkg;

	localparam int BUTTONS   = 6;
	localparam int KEY_W     = 8;
	localparam int STORE_W   = 6;
	localparam int PAUSE_IDX = 6;
	localparam int CNT_W     = 10;
	localparam int DN_W      = 10;
	localparam int X_W       = 11;
	localparam int REM_W     = 9;
	localparam int STEPS     = X_W;
	localparam int STEP_W    = $clog2(STEPS);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;

	localparam logic [KEY_W-1:0] BTN_MASK = KEY_W'((1 << BUTTONS) - 1);

	localparam logic [CFG_W-1:0] DELAY_DEFAULT    = 8'd15;
	localparam logic [CFG_W-1:0] INTERVAL_DEFAULT = 8'd4;
	localparam logic [CFG_W-1:0] REPEAT_OFF       = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] host_pressed;
		logic [KEY_W-1:0] host_held;
	} in_t;

	typedef struct packed {
		logic [KEY_W-1:0]   pressed_mask;
		logic [KEY_W-1:0]   held_mask;
		logic [STORE_W-1:0] stored_buttons;
	} out_t;

	typedef struct packed {
		logic              start;
		logic              step;
		logic              finish;
		logic [STEP_W-1:0] bit_idx;
	} lane_ctrl_t;

	typedef struct packed {
		logic [DN_W-1:0] delay;
		logic [DN_W-1:0] interval;
		logic            repeat_on;
	} lane_cfg_t;

endpackage

// File: sv/button_press_autorepeat.sv
// Button press and autorepeat: top level with registers, sequencer and lanes.
// A request is taken only in idle; in_stall holds until its result is loaded, so a
// new request waits for the last. Steps: the accept, the 11-step remainder loop in
// each lane, then folding the counters and loading the output once it is free.
// Reset clears the registers, the counters, the previous held mask and valid.
// Depends on bpa_pkg, bpa_lane and bpa_merge.

module button_press_autorepeat import bpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]         state_q;
	logic [STEP_W-1:0]  bit_q;
	logic [CFG_W-1:0]   delay_q;
	logic [CFG_W-1:0]   interval_q;
	logic               rate_q;
	logic [KEY_W-1:0]   last_held_q;
	logic [KEY_W-1:0]   base_q;
	logic [KEY_W-1:0]   kheld_q;
	logic               accept;
	logic               load;
	logic               merge_ready;
	logic [CFG_W-1:0]   dly;
	logic [CFG_W-1:0]   ivl;
	lane_ctrl_t         lane_ctrl;
	lane_cfg_t          lane_cfg;
	logic [BUTTONS-1:0] rpt;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load     = (state_q == S_FIN) && merge_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= '0;
			interval_q <= '0;
			rate_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY:    delay_q    <= cfg_data;
				REG_INTERVAL: interval_q <= cfg_data;
				REG_RATE:     rate_q     <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	assign dly = (delay_q == '0) ? DELAY_DEFAULT : delay_q;
	assign ivl = (interval_q == '0) ? INTERVAL_DEFAULT : interval_q;

	always_comb begin
		lane_cfg.delay     = rate_q ? DN_W'({dly, 1'b0}) : DN_W'(dly);
		lane_cfg.interval  = rate_q ? DN_W'({ivl, 1'b0}) : DN_W'(ivl);
		lane_cfg.repeat_on = (dly != REPEAT_OFF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bit_q       <= '0;
			last_held_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_RUN;
						bit_q       <= STEP_W'(STEPS - 1);
						last_held_q <= in_data.host_held;
					end
				end
				S_RUN: begin
					if (bit_q == '0) begin
						state_q <= S_FIN;
					end else begin
						bit_q <= bit_q - STEP_W'(1);
					end
				end
				S_FIN: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= in_data.host_pressed |
				(in_data.host_held & ~last_held_q & BTN_MASK);
			kheld_q <= in_data.host_held;
		end
	end

	always_comb begin
		lane_ctrl.start   = accept;
		lane_ctrl.step    = (state_q == S_RUN);
		lane_ctrl.finish  = load;
		lane_ctrl.bit_idx = bit_q;
	end

	for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
		bpa_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.cfg    (lane_cfg),
			.down   (in_data.host_held[g]),
			.prev   (last_held_q[g]),
			.rpt    (rpt[g])
		);
	end

	bpa_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.base_pressed (base_q),
		.kheld        (kheld_q),
		.rpt          (rpt),
		.ready        (merge_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

endmodule

// File: sv/bpa_lane.sv
// One button lane: held-frame counter with fold-back and repeat detection.
// The remainder is found one bit a cycle by restoring subtraction. Uses bpa_pkg.

module bpa_lane import bpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  lane_cfg_t  cfg,
	input  logic       down,
	input  logic       prev,
	output logic       rpt
);

	logic [CNT_W-1:0] cnt_q;
	logic [X_W-1:0]   c_q;
	logic [X_W-1:0]   x_q;
	logic [REM_W-1:0] rem_q;
	logic             zero_q;
	logic [X_W-1:0]   c_next;
	logic [REM_W:0]   trial;
	logic [X_W-1:0]   limit;

	assign c_next = X_W'(cnt_q) + X_W'(1);
	assign trial  = {rem_q, x_q[ctrl.bit_idx]};
	assign limit  = X_W'(cfg.delay) + X_W'(cfg.interval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.finish) begin
			if (zero_q) begin
				cnt_q <= '0;
			end else if (c_q >= limit) begin
				cnt_q <= cfg.delay + CNT_W'(rem_q);
			end else begin
				cnt_q <= c_q[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			zero_q <= !(down && prev);
			c_q    <= c_next;
			x_q    <= c_next - X_W'(cfg.delay);
			rem_q  <= '0;
		end else if (ctrl.step) begin
			if (trial >= (REM_W+1)'(cfg.interval)) begin
				rem_q <= REM_W'(trial - (REM_W+1)'(cfg.interval));
			end else begin
				rem_q <= trial[REM_W-1:0];
			end
		end
	end

	assign rpt = !zero_q && cfg.repeat_on && (c_q >= X_W'(cfg.delay)) && (rem_q == '0);

endmodule

// File: sv/bpa_merge.sv
// Merging stage and output register: combines edge presses with lane repeats.
// Applies the pause rule and holds the result until taken. Uses bpa_pkg.

module bpa_merge import bpa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [KEY_W-1:0]   base_pressed,
	input  logic [KEY_W-1:0]   kheld,
	input  logic [BUTTONS-1:0] rpt,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_data
);

	logic out_valid_q;
	out_t out_q;
	logic [KEY_W-1:0] held;

	always_comb begin
		held = kheld;
		if (kheld[PAUSE_IDX] && !base_pressed[PAUSE_IDX]) begin
			held[PAUSE_IDX] = 1'b0;
		end
	end

	assign ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.pressed_mask   <= base_pressed | KEY_W'(rpt);
			out_q.held_mask      <= held;
			out_q.stored_buttons <= kheld[STORE_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
